/* hdl/time_of_day_arith_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef TIME_OF_DAY_ARITH_UNIT_ASSERT_SVH
`define TIME_OF_DAY_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TOD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TOD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hdl/tod_arith_pkg.sv */
package tod_arith_pkg;

  localparam int unsigned ReqW   = 3;
  localparam int unsigned ShiftW = 32;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned DiffW  = 18;
  localparam int unsigned TotW   = 17;
  localparam int unsigned SumW   = 19;
  localparam int unsigned RemW   = 12;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MaxHour     = 23;
  localparam int unsigned MaxMinSec   = 59;

  localparam int unsigned NumStages = 8;

  // residue of 2**32 folds a negative shift back into range
  localparam longint unsigned Wrap32Res = (64'd1 << 32) % SecsPerDay;
  localparam longint unsigned NegCorr   = SecsPerDay - Wrap32Res;

  // reciprocal multiplies for the constant divides
  localparam int unsigned HourRecip      = 37283;
  localparam int unsigned HourRecipShift = 27;
  localparam int unsigned HourProdW      = TotW + 16;
  localparam int unsigned MinRecip       = 2185;
  localparam int unsigned MinRecipShift  = 17;
  localparam int unsigned MinProdW       = RemW + 12;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK_FWD  = 3'd0,
    REQ_TICK_BACK = 3'd1,
    REQ_SHIFT     = 3'd2,
    REQ_LOAD      = 3'd3,
    REQ_DIFF      = 3'd4
  } req_e;

  typedef logic [TotW-1:0] res_tbl_t [256];

  // residue modulo one day of each value of one byte of the shift
  function automatic res_tbl_t build_res_tbl(input int unsigned byte_pos);
    res_tbl_t           tbl;
    longint unsigned    weight;
    weight = (64'd1 << (8 * byte_pos)) % SecsPerDay;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = TotW'((longint'(i) * weight) % SecsPerDay);
    end
    return tbl;
  endfunction

  localparam res_tbl_t ResByte2 = build_res_tbl(2);
  localparam res_tbl_t ResByte3 = build_res_tbl(3);

endpackage

/* hdl/tod_arith_if.sv */
interface tod_arith_req_if import tod_arith_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ReqW-1:0]          req_type;
  logic signed [ShiftW-1:0] shift_seconds;
  logic [HourW-1:0]         given_hour;
  logic [MinW-1:0]          given_minute;
  logic [MinW-1:0]          given_second;

  modport source (
    output valid, req_type, shift_seconds, given_hour, given_minute, given_second,
    input  ready
  );
  modport sink (
    input  valid, req_type, shift_seconds, given_hour, given_minute, given_second,
    output ready
  );
endinterface

interface tod_arith_rsp_if import tod_arith_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [HourW-1:0]        now_hour;
  logic [MinW-1:0]         now_minute;
  logic [MinW-1:0]         now_second;
  logic signed [DiffW-1:0] diff_seconds;

  modport source (
    output valid, now_hour, now_minute, now_second, diff_seconds,
    input  ready
  );
  modport sink (
    input  valid, now_hour, now_minute, now_second, diff_seconds,
    output ready
  );
endinterface

/* hdl/time_of_day_arith_unit.sv */
// Throughput: one request per cycle unless a stalled result backs up every
// stage; the stored time is a single 17-bit seconds-of-day register updated
// at most once per request, by a wrapping tick or add-and-wrap, or a load.
// Eight register stages; a stalled result only holds the stages behind it.
// Reset: stored time goes to 00:00:00 and every stage is emptied.
module time_of_day_arith_unit import tod_arith_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tod_arith_req_if.sink   req_i,
  tod_arith_rsp_if.source rsp_o
);

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;

  logic [TotW-1:0] total_q, total_d;

  // stage 0: request register
  logic [ReqW-1:0]   s0_req_q;
  logic [ShiftW-1:0] s0_shift_q;
  logic [HourW-1:0]  s0_hour_q;
  logic [MinW-1:0]   s0_min_q, s0_sec_q;

  // stage 1: residue partial sum, given time
  logic [ReqW-1:0] s1_req_q;
  logic [SumW-1:0] s1_psum_q, psum_d;
  logic [TotW-1:0] s1_gtot_q, gtot_d;
  logic            s1_load_ok_q, load_ok_d;
  logic [HourW-1:0] gh_sat;
  logic [MinW-1:0]  gm_sat, gs_sat;

  // stage 2: reduced shift
  logic [ReqW-1:0] s2_req_q;
  logic [TotW-1:0] s2_res_q, res_d;
  logic [TotW-1:0] s2_gtot_q;
  logic            s2_load_ok_q;

  // stage 3 onwards: split seconds of day into h:m:s
  logic [TotW-1:0]         s3_tot_q;
  logic signed [DiffW-1:0] s3_diff_q, diff_d;
  logic [TotW:0]           shift_sum;

  logic [HourProdW-1:0]    hour_prod;
  logic [HourW-1:0]        s4_hour_q;
  logic [TotW-1:0]         s4_tot_q;
  logic signed [DiffW-1:0] s4_diff_q;

  logic [TotW-1:0]         rem_full;
  logic [HourW-1:0]        s5_hour_q;
  logic [RemW-1:0]         s5_rem_q;
  logic signed [DiffW-1:0] s5_diff_q;

  logic [MinProdW-1:0]     min_prod;
  logic [HourW-1:0]        s6_hour_q;
  logic [MinW-1:0]         s6_min_q;
  logic [RemW-1:0]         s6_rem_q;
  logic signed [DiffW-1:0] s6_diff_q;

  logic [RemW-1:0]         sec_full;
  logic [HourW-1:0]        s7_hour_q;
  logic [MinW-1:0]         s7_min_q, s7_sec_q;
  logic signed [DiffW-1:0] s7_diff_q;

  // flow control: a stage loads when empty or when the next one loads
  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || rsp_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign req_i.ready = rdy[0];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_req_q   <= req_i.req_type;
      s0_shift_q <= req_i.shift_seconds;
      s0_hour_q  <= req_i.given_hour;
      s0_min_q   <= req_i.given_minute;
      s0_sec_q   <= req_i.given_second;
    end
  end

  // shift mod one day: low half plus per-byte residues, plus 2**32 fold
  always_comb begin
    psum_d = SumW'(s0_shift_q[15:0])
           + SumW'(ResByte2[s0_shift_q[23:16]])
           + SumW'(ResByte3[s0_shift_q[31:24]])
           + (s0_shift_q[ShiftW-1] ? SumW'(NegCorr) : SumW'(0));

    gh_sat = (s0_hour_q > HourW'(MaxHour))  ? HourW'(MaxHour)  : s0_hour_q;
    gm_sat = (s0_min_q > MinW'(MaxMinSec))  ? MinW'(MaxMinSec) : s0_min_q;
    gs_sat = (s0_sec_q > MinW'(MaxMinSec))  ? MinW'(MaxMinSec) : s0_sec_q;

    load_ok_d = (s0_hour_q <= HourW'(MaxHour)) && (s0_min_q <= MinW'(MaxMinSec))
             && (s0_sec_q <= MinW'(MaxMinSec));

    gtot_d = TotW'(gh_sat) * TotW'(SecsPerHour) + TotW'(gm_sat) * TotW'(SecsPerMin)
           + TotW'(gs_sat);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_req_q     <= s0_req_q;
      s1_psum_q    <= psum_d;
      s1_gtot_q    <= gtot_d;
      s1_load_ok_q <= load_ok_d;
    end
  end

  always_comb begin
    if (s1_psum_q >= SumW'(3 * SecsPerDay)) begin
      res_d = TotW'(s1_psum_q - SumW'(3 * SecsPerDay));
    end else if (s1_psum_q >= SumW'(2 * SecsPerDay)) begin
      res_d = TotW'(s1_psum_q - SumW'(2 * SecsPerDay));
    end else if (s1_psum_q >= SumW'(SecsPerDay)) begin
      res_d = TotW'(s1_psum_q - SumW'(SecsPerDay));
    end else begin
      res_d = TotW'(s1_psum_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_req_q     <= s1_req_q;
      s2_res_q     <= res_d;
      s2_gtot_q    <= s1_gtot_q;
      s2_load_ok_q <= s1_load_ok_q;
    end
  end

  // time-of-day update
  always_comb begin
    total_d   = total_q;
    diff_d    = '0;
    shift_sum = {1'b0, total_q} + {1'b0, s2_res_q};
    case (s2_req_q)
      REQ_TICK_FWD: begin
        total_d = (total_q == TotW'(SecsPerDay - 1)) ? '0 : total_q + TotW'(1);
      end
      REQ_TICK_BACK: begin
        total_d = (total_q == '0) ? TotW'(SecsPerDay - 1) : total_q - TotW'(1);
      end
      REQ_SHIFT: begin
        total_d = (shift_sum >= (TotW+1)'(SecsPerDay))
                ? TotW'(shift_sum - (TotW+1)'(SecsPerDay)) : TotW'(shift_sum);
      end
      REQ_LOAD: begin
        if (s2_load_ok_q) begin
          total_d = s2_gtot_q;
        end
      end
      REQ_DIFF: begin
        diff_d = $signed({1'b0, total_q}) - $signed({1'b0, s2_gtot_q});
      end
      default: begin
        total_d = total_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (vld_q[2] && rdy[3]) begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_tot_q  <= total_d;
      s3_diff_q <= diff_d;
    end
  end

  assign hour_prod = HourProdW'(s3_tot_q) * HourProdW'(HourRecip);

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_hour_q <= hour_prod[HourRecipShift +: HourW];
      s4_tot_q  <= s3_tot_q;
      s4_diff_q <= s3_diff_q;
    end
  end

  assign rem_full = s4_tot_q - TotW'(s4_hour_q) * TotW'(SecsPerHour);

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_hour_q <= s4_hour_q;
      s5_rem_q  <= rem_full[RemW-1:0];
      s5_diff_q <= s4_diff_q;
    end
  end

  assign min_prod = MinProdW'(s5_rem_q) * MinProdW'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s6_hour_q <= s5_hour_q;
      s6_min_q  <= min_prod[MinRecipShift +: MinW];
      s6_rem_q  <= s5_rem_q;
      s6_diff_q <= s5_diff_q;
    end
  end

  assign sec_full = s6_rem_q - RemW'(s6_min_q) * RemW'(SecsPerMin);

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s7_hour_q <= s6_hour_q;
      s7_min_q  <= s6_min_q;
      s7_sec_q  <= sec_full[MinW-1:0];
      s7_diff_q <= s6_diff_q;
    end
  end

  assign rsp_o.valid        = vld_q[NumStages-1];
  assign rsp_o.now_hour     = s7_hour_q;
  assign rsp_o.now_minute   = s7_min_q;
  assign rsp_o.now_second   = s7_sec_q;
  assign rsp_o.diff_seconds = s7_diff_q;

endmodule

/* hdl/tod_arith_chk.sv */
`include "time_of_day_arith_unit_assert.svh"

module tod_arith_chk import tod_arith_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [HourW-1:0]        now_hour_i,
  input logic [MinW-1:0]         now_minute_i,
  input logic [MinW-1:0]         now_second_i,
  input logic signed [DiffW-1:0] diff_seconds_i
);

  `TOD_ASSERT_NXT(a_rsp_valid_held, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `TOD_ASSERT_NXT(a_rsp_payload_held, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(now_hour_i) && $stable(now_minute_i) && $stable(now_second_i) && $stable(diff_seconds_i))
  `TOD_ASSERT_IMP(a_time_in_range, clk_i, rst_ni, rsp_valid_i, (now_hour_i <= HourW'(MaxHour)) && (now_minute_i <= MinW'(MaxMinSec)) && (now_second_i <= MinW'(MaxMinSec)))
  `TOD_ASSERT_IMP(a_diff_in_range, clk_i, rst_ni, rsp_valid_i, (diff_seconds_i >= -18'sd86399) && (diff_seconds_i <= 18'sd86399))

endmodule

bind time_of_day_arith_unit tod_arith_chk u_tod_arith_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .now_hour_i     (rsp_o.now_hour),
  .now_minute_i   (rsp_o.now_minute),
  .now_second_i   (rsp_o.now_second),
  .diff_seconds_i (rsp_o.diff_seconds)
);

/* verif/time_of_day_arith_unit_tb.sv */
`timescale 1ns / 100ps

import tod_arith_pkg::*;

typedef struct {
  logic [ReqW-1:0]          req_type;
  logic signed [ShiftW-1:0] shift_seconds;
  logic [HourW-1:0]         given_hour;
  logic [MinW-1:0]          given_minute;
  logic [MinW-1:0]          given_second;
} tod_req_t;

typedef struct {
  logic [HourW-1:0]        now_hour;
  logic [MinW-1:0]         now_minute;
  logic [MinW-1:0]         now_second;
  logic signed [DiffW-1:0] diff_seconds;
} tod_rsp_t;

class tod_time_scoreboard;
  longint      secs_of_day;
  tod_rsp_t    expected_times[$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned loads_rejected;
  int unsigned per_code[8];

  function new();
    secs_of_day = 0;
    mismatches = 0;
    results_checked = 0;
    loads_rejected = 0;
    foreach (per_code[i]) per_code[i] = 0;
  endfunction

  function longint secs_of(logic [HourW-1:0] h, logic [MinW-1:0] m, logic [MinW-1:0] s);
    return longint'(h) * longint'(SecsPerHour) + longint'(m) * longint'(SecsPerMin) +
           longint'(s);
  endfunction

  // exact modulo one day, truncating remainder then one fold
  function void advance(longint delta);
    longint t;
    t = secs_of_day + delta % longint'(SecsPerDay);
    if (t < 0) t += longint'(SecsPerDay);
    else if (t >= longint'(SecsPerDay)) t -= longint'(SecsPerDay);
    secs_of_day = t;
  endfunction

  function void note_request(tod_req_t r);
    logic [HourW-1:0] gh;
    logic [MinW-1:0]  gm;
    logic [MinW-1:0]  gs;
    longint           diff;
    tod_rsp_t         want;
    gh = r.given_hour;
    gm = r.given_minute;
    gs = r.given_second;
    diff = 0;
    per_code[r.req_type]++;
    case (r.req_type)
      REQ_TICK_FWD:  advance(1);
      REQ_TICK_BACK: advance(-1);
      REQ_SHIFT:     advance(longint'(r.shift_seconds));
      REQ_LOAD: begin
        if (gh <= HourW'(MaxHour) && gm <= MinW'(MaxMinSec) && gs <= MinW'(MaxMinSec)) begin
          secs_of_day = secs_of(gh, gm, gs);
        end else begin
          loads_rejected++;
        end
      end
      REQ_DIFF: begin
        if (gh > HourW'(MaxHour)) gh = HourW'(MaxHour);
        if (gm > MinW'(MaxMinSec)) gm = MinW'(MaxMinSec);
        if (gs > MinW'(MaxMinSec)) gs = MinW'(MaxMinSec);
        diff = secs_of_day - secs_of(gh, gm, gs);
      end
      default: ;
    endcase
    want.now_hour     = HourW'(secs_of_day / longint'(SecsPerHour));
    want.now_minute   = MinW'((secs_of_day % longint'(SecsPerHour)) / longint'(SecsPerMin));
    want.now_second   = MinW'(secs_of_day % longint'(SecsPerMin));
    want.diff_seconds = DiffW'(diff);
    expected_times.push_back(want);
  endfunction

  function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(tod_rsp_t got);
    tod_rsp_t want;
    if (expected_times.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing pending, expected none, actual %0d:%0d:%0d diff %0d",
               $time, got.now_hour, got.now_minute, got.now_second, got.diff_seconds);
      return;
    end
    want = expected_times.pop_front();
    results_checked++;
    compare_field("now_hour", 32'(want.now_hour), 32'(got.now_hour));
    compare_field("now_minute", 32'(want.now_minute), 32'(got.now_minute));
    compare_field("now_second", 32'(want.now_second), 32'(got.now_second));
    compare_field("diff_seconds", 32'(want.diff_seconds), 32'(got.diff_seconds));
  endfunction
endclass

module time_of_day_arith_unit_tb;

  localparam int unsigned RandomRequests = 1150;
  localparam int unsigned IdleLimit      = 4000;
  localparam int unsigned DrainCycles    = 24;
  localparam int unsigned ResetCycles    = 12;

  localparam logic [ReqW-1:0] ReqSpareFirst = 3'd5;
  localparam logic [ReqW-1:0] ReqSpareLast  = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic clk_i;
  logic rst_ni;

  tod_arith_req_if req_if ();
  tod_arith_rsp_if rsp_if ();

  time_of_day_arith_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  tod_time_scoreboard tracker = new();
  int unsigned        burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    tod_req_t r;
    tod_rsp_t got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        r.req_type      = req_if.req_type;
        r.shift_seconds = req_if.shift_seconds;
        r.given_hour    = req_if.given_hour;
        r.given_minute  = req_if.given_minute;
        r.given_second  = req_if.given_second;
        tracker.note_request(r);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.now_hour     = rsp_if.now_hour;
        got.now_minute   = rsp_if.now_minute;
        got.now_second   = rsp_if.now_second;
        got.diff_seconds = rsp_if.diff_seconds;
        tracker.check_result(got);
      end
    end
  end

  // receiver back-pressure
  initial begin
    stall_mode_e mode;
    int unsigned seg_left;
    int unsigned phase;
    mode = STALL_NONE;
    seg_left = 0;
    phase = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (seg_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(5, 120);
      end
      seg_left--;
      phase++;
      case (mode)
        STALL_NONE:  rsp_if.ready <= 1'b1;
        STALL_COIN:  rsp_if.ready <= ($urandom_range(0, 1) == 1);
        STALL_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default:     rsp_if.ready <= ((phase % 7) < 3);
      endcase
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
    $display("time_of_day_arith_unit_tb: errors");
    $finish;
  end

  function automatic tod_req_t make_request(logic [ReqW-1:0] code, logic signed [ShiftW-1:0] shift,
                                            int unsigned h, int unsigned m, int unsigned s);
    tod_req_t r;
    r.req_type      = code;
    r.shift_seconds = shift;
    r.given_hour    = HourW'(h);
    r.given_minute  = MinW'(m);
    r.given_second  = MinW'(s);
    return r;
  endfunction

  function automatic tod_req_t random_request();
    tod_req_t    r;
    int unsigned sel;
    int unsigned pick;
    sel = $urandom_range(0, 99);
    r = make_request(REQ_TICK_FWD, $urandom(), $urandom(), $urandom(), $urandom());
    if (sel < 18) r.req_type = REQ_TICK_FWD;
    else if (sel < 36) r.req_type = REQ_TICK_BACK;
    else if (sel < 58) begin
      r.req_type = REQ_SHIFT;
      pick = $urandom_range(0, 9);
      if (pick < 4) r.shift_seconds = ShiftW'(int'($urandom_range(0, 200)) - 100);
      else if (pick < 6) r.shift_seconds = ShiftW'(int'($urandom_range(0, 4)) *
                                                   int'(SecsPerDay) * ($urandom_range(0, 1) ? 1 : -1) +
                                                   int'($urandom_range(0, 6)) - 3);
      else if (pick == 6) r.shift_seconds = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else if (pick == 7) r.shift_seconds = ShiftW'(int'($urandom_range(0, 2 * SecsPerDay)) -
                                                   int'(SecsPerDay));
    end else if (sel < 94) begin
      r.req_type = (sel < 74) ? REQ_LOAD : REQ_DIFF;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        r.given_hour   = $urandom_range(0, 1) ? HourW'(MaxHour) : '0;
        r.given_minute = $urandom_range(0, 1) ? MinW'(MaxMinSec) : '0;
        r.given_second = $urandom_range(0, 1) ? MinW'(MaxMinSec) : '0;
      end else if (pick < 8) begin
        r.given_hour   = HourW'($urandom_range(0, MaxHour));
        r.given_minute = MinW'($urandom_range(0, MaxMinSec));
        r.given_second = MinW'($urandom_range(0, MaxMinSec));
      end
    end else r.req_type = ReqW'($urandom_range(ReqSpareFirst, ReqSpareLast));
    return r;
  endfunction

  task automatic send_request(input tod_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    req_if.valid         <= 1'b1;
    req_if.req_type      <= r.req_type;
    req_if.shift_seconds <= r.shift_seconds;
    req_if.given_hour    <= r.given_hour;
    req_if.given_minute  <= r.given_minute;
    req_if.given_second  <= r.given_second;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  initial begin
    int unsigned spare_total;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_TICK_FWD;
    req_if.shift_seconds <= '0;
    req_if.given_hour    <= '0;
    req_if.given_minute  <= '0;
    req_if.given_second  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // midnight wraps, full-day differences
    send_request(make_request(REQ_TICK_BACK, 0, 0, 0, 0));
    send_request(make_request(REQ_TICK_FWD, 0, 0, 0, 0));
    send_request(make_request(REQ_LOAD, 0, 23, 59, 59));
    send_request(make_request(REQ_DIFF, 0, 0, 0, 0));
    send_request(make_request(REQ_TICK_FWD, 0, 0, 0, 0));
    send_request(make_request(REQ_DIFF, 0, 23, 59, 59));
    // rejected loads
    send_request(make_request(REQ_LOAD, 0, 31, 63, 63));
    send_request(make_request(REQ_LOAD, 0, 24, 0, 0));
    send_request(make_request(REQ_LOAD, 0, 12, 60, 0));
    send_request(make_request(REQ_LOAD, 0, 12, 0, 60));
    // shift extremes and multi-day shifts
    send_request(make_request(REQ_SHIFT, 32'sh7FFF_FFFF, 0, 0, 0));
    send_request(make_request(REQ_SHIFT, -32'sd2147483647, 0, 0, 0));
    send_request(make_request(REQ_SHIFT, 32'sh8000_0000, 0, 0, 0));
    send_request(make_request(REQ_SHIFT, 0, 0, 0, 0));
    send_request(make_request(REQ_SHIFT, -32'sd86401, 0, 0, 0));
    send_request(make_request(REQ_SHIFT, 32'sd86400, 0, 0, 0));
    send_request(make_request(REQ_SHIFT, -32'sd1, 0, 0, 0));
    // saturating compare
    send_request(make_request(REQ_DIFF, 0, 31, 63, 63));
    send_request(make_request(REQ_DIFF, 0, 5, 60, 30));
    for (int c = ReqSpareFirst; c <= ReqSpareLast; c++) begin
      send_request(make_request(ReqW'(c), $urandom(), $urandom(), $urandom(), $urandom()));
    end
    send_request(make_request(REQ_LOAD, 0, 12, 34, 56));

    repeat (RandomRequests) send_request(random_request());
    req_if.valid <= 1'b0;

    while (tracker.expected_times.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    spare_total = tracker.per_code[5] + tracker.per_code[6] + tracker.per_code[7];
    $display("covered %0d results: tick fwd %0d, tick back %0d, shift %0d, load %0d (%0d rejected)",
             tracker.results_checked, tracker.per_code[REQ_TICK_FWD],
             tracker.per_code[REQ_TICK_BACK], tracker.per_code[REQ_SHIFT],
             tracker.per_code[REQ_LOAD], tracker.loads_rejected);
    $display("difference %0d, spare codes %0d, mismatches %0d",
             tracker.per_code[REQ_DIFF], spare_total, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("time_of_day_arith_unit_tb: clean");
    end else begin
      $display("time_of_day_arith_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/tod_arith_pkg.sv
hdl/tod_arith_if.sv
hdl/time_of_day_arith_unit.sv
hdl/tod_arith_chk.sv
verif/time_of_day_arith_unit_tb.sv
